@@ rtl/bba_pkg.sv @@
// Shared types, constants and microcode table for the bitmap block allocator.
package bba_pkg;

    localparam int MAP_BITS  = 1024;
    localparam int MAP_WORDS = (MAP_BITS + 63) / 64;
    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int GIDX_W    = WIDX_W + 6;
    localparam int CNT_W     = GIDX_W + 1;
    localparam int WIDE_W    = 17;
    localparam int BN_W      = 16;
    localparam int BC_W      = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;
    localparam logic [BC_W-1:0]      BLOCK_COUNT_RST = 11'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREE  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_ARD, S_ATST, S_AEND, S_ASET, S_AFULL,
        S_FRD, S_FTST, S_FCLR, S_FFREE, S_FBAD, S_DONE
    } t_step;

    typedef enum logic [2:0] {
        C_ALWAYS, C_IN_FIRE, C_OP_FREE, C_SCAN_END,
        C_FOUND, C_RANGE_BAD, C_BIT_SET, C_OUT_FREE
    } t_cond;

    typedef enum logic [1:0] {RD_NONE, RD_FIRST, RD_NEXT, RD_OFF} t_rd;
    typedef enum logic [1:0] {WR_NONE, WR_SET, WR_CLR} t_wr;
    typedef enum logic [1:0] {RES_KEEP, RES_BN, RES_ZERO} t_res;

    typedef struct packed {
        t_cond   cond;
        t_step   tgt_t;
        t_step   tgt_f;
        t_rd     rd;
        t_wr     wr;
        t_res    res;
        logic    ld_st;
        t_status st;
        logic    take;
        logic    ld_in;
        logic    scan;
        logic    push;
    } t_uop;

    typedef struct packed {
        logic in_fire;
        logic op_free;
        logic scan_end;
        logic found;
        logic range_bad;
        logic bit_set;
        logic out_free;
    } t_flags;

    // microcode: one control word per step, two jump targets chosen by cond
    function automatic t_uop uop_rom(t_step s);
        t_uop u;
        u.cond  = C_ALWAYS;
        u.tgt_t = S_IDLE;
        u.tgt_f = S_IDLE;
        u.rd    = RD_NONE;
        u.wr    = WR_NONE;
        u.res   = RES_KEEP;
        u.ld_st = 1'b0;
        u.st    = ST_OK;
        u.take  = 1'b0;
        u.ld_in = 1'b0;
        u.scan  = 1'b0;
        u.push  = 1'b0;
        case (s)
            S_IDLE: begin
                u.cond = C_IN_FIRE; u.tgt_t = S_DISP; u.tgt_f = S_IDLE;
                u.take = 1'b1; u.ld_in = 1'b1;
            end
            S_DISP: begin
                u.cond = C_OP_FREE; u.tgt_t = S_FRD; u.tgt_f = S_ARD;
            end
            S_ARD: begin
                u.tgt_t = S_ATST; u.rd = RD_FIRST;
            end
            S_ATST: begin
                // test the word read last cycle, fetch the next one
                u.cond = C_SCAN_END; u.tgt_t = S_AEND; u.tgt_f = S_ATST;
                u.rd = RD_NEXT; u.scan = 1'b1;
            end
            S_AEND: begin
                u.cond = C_FOUND; u.tgt_t = S_ASET; u.tgt_f = S_AFULL;
            end
            S_ASET: begin
                u.tgt_t = S_DONE; u.wr = WR_SET; u.ld_st = 1'b1; u.st = ST_OK;
            end
            S_AFULL: begin
                u.tgt_t = S_DONE; u.res = RES_ZERO; u.ld_st = 1'b1; u.st = ST_FULL;
            end
            S_FRD: begin
                u.cond = C_RANGE_BAD; u.tgt_t = S_FBAD; u.tgt_f = S_FTST;
                u.rd = RD_OFF;
            end
            S_FTST: begin
                // keep the target word on the read port for the clear step
                u.cond = C_BIT_SET; u.tgt_t = S_FCLR; u.tgt_f = S_FFREE;
                u.rd = RD_OFF;
            end
            S_FCLR: begin
                u.tgt_t = S_DONE; u.wr = WR_CLR; u.res = RES_BN;
                u.ld_st = 1'b1; u.st = ST_OK;
            end
            S_FFREE: begin
                u.tgt_t = S_DONE; u.res = RES_ZERO; u.ld_st = 1'b1; u.st = ST_FREE;
            end
            S_FBAD: begin
                u.tgt_t = S_DONE; u.res = RES_ZERO; u.ld_st = 1'b1; u.st = ST_RANGE;
            end
            S_DONE: begin
                u.cond = C_OUT_FREE; u.tgt_t = S_IDLE; u.tgt_f = S_DONE;
                u.push = 1'b1;
            end
            default: begin
                u.tgt_t = S_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

@@ rtl/bba_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module bba_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bba_pkg::t_flags i_flags,
    output bba_pkg::t_uop   o_uop
);

    bba_pkg::t_step r_pc;
    bba_pkg::t_step n_pc;
    bba_pkg::t_uop  uop;
    logic           cond_hit;

    assign uop = bba_pkg::uop_rom(r_pc);

    // next step
    always_comb begin
        case (uop.cond)
            bba_pkg::C_ALWAYS:    cond_hit = 1'b1;
            bba_pkg::C_IN_FIRE:   cond_hit = i_flags.in_fire;
            bba_pkg::C_OP_FREE:   cond_hit = i_flags.op_free;
            bba_pkg::C_SCAN_END:  cond_hit = i_flags.scan_end;
            bba_pkg::C_FOUND:     cond_hit = i_flags.found;
            bba_pkg::C_RANGE_BAD: cond_hit = i_flags.range_bad;
            bba_pkg::C_BIT_SET:   cond_hit = i_flags.bit_set;
            bba_pkg::C_OUT_FREE:  cond_hit = i_flags.out_free;
            default:              cond_hit = 1'b1;
        endcase
        n_pc = cond_hit ? uop.tgt_t : uop.tgt_f;
    end

    // control word out
    always_comb begin
        o_uop = uop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bba_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// Top level: first-fit bitmap block allocator with microcoded control.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word: i_op (0 allocate,
//   1 free) and i_block_number (block to free). Output channel (o_out_valid /
//   i_out_ready) returns one word per request: o_block_number_res and
//   o_status (0 ok, 1 no free block, 2 out of range, 3 already free).
//   Config port: i_cfg_we with i_cfg_idx 0 writes data_base, 1 writes
//   block_count (low 11 bits); write only while no request is in flight.
// Sequencing:
//   Free reads the target word, tests its bit and clears it, or reports it
//   already free; a block out of range goes straight to the error result.
//   Allocate scans the bitmap one 64-bit word per cycle out of a 16-word
//   memory with one read and one write port, from word 0 up to the first
//   word with a free bit or the end of the managed range (1 to 16 words).
//   One request is worked at a time; the next word is taken at the earliest
//   the cycle after the previous result lands in the output register.
// Reset: synchronous, active low. The bitmap reads as all free at once
//   (per-word valid flops), data_base = 0, block_count = 1024.
// Stall: a held result keeps the sequencer in its final step; at most one
//   more request is accepted and worked while the receiver stalls.
module bitmap_block_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [bba_pkg::BN_W-1:0]           i_block_number,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bba_pkg::BN_W-1:0]           o_block_number_res,
    output logic [1:0]                         o_status,
    input  logic                               i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bba_pkg::BN_W-1:0]           i_cfg_data
);

    bba_pkg::t_uop   uop;
    bba_pkg::t_flags flags;

    // config
    logic [bba_pkg::BN_W-1:0]   r_data_base;
    logic [bba_pkg::BC_W-1:0]   r_block_count;

    // request
    logic                       r_op;
    logic [bba_pkg::BN_W-1:0]   r_bn;
    logic [bba_pkg::CNT_W-1:0]  r_n;
    logic [bba_pkg::CNT_W-1:0]  n_n;

    // bitmap memory
    logic [63:0]                r_map [bba_pkg::MAP_WORDS];
    logic                       r_map_vld [bba_pkg::MAP_WORDS];
    logic [63:0]                r_rd_raw;
    logic                       r_rd_vld;
    logic [63:0]                rdata;
    logic [bba_pkg::WIDX_W-1:0] rd_addr;
    logic [bba_pkg::WIDX_W-1:0] wr_addr;
    logic [63:0]                wr_data;
    logic                       wr_en;

    // scan
    logic [bba_pkg::WIDX_W-1:0] r_widx;
    logic                       r_found;
    logic [bba_pkg::WIDX_W-1:0] r_fw;
    logic [63:0]                r_fword;
    logic [bba_pkg::CNT_W-1:0]  wbase;
    logic [bba_pkg::CNT_W-1:0]  rem_full;
    logic [6:0]                 rem7;
    logic [63:0]                avail;
    logic [63:0]                free_bits;
    logic [63:0]                iso;
    logic [5:0]                 bidx;
    logic                       found;
    logic                       more;

    // free path
    logic [bba_pkg::BN_W-1:0]   off;
    logic [bba_pkg::WIDX_W-1:0] offw;
    logic [5:0]                 offb;
    logic                       range_bad;

    // result
    logic [bba_pkg::BN_W-1:0]   r_res;
    bba_pkg::t_status           r_st;
    logic                       r_ovalid;
    logic [bba_pkg::BN_W-1:0]   r_out_bn;
    bba_pkg::t_status           r_out_st;
    logic                       in_fire;
    logic                       out_free;
    logic                       push;

    bba_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uop   (uop)
    );

    assign o_in_ready         = uop.take;
    assign in_fire            = uop.take & i_in_valid;
    assign out_free           = !r_ovalid || i_out_ready;
    assign push               = uop.push & out_free;
    assign o_out_valid        = r_ovalid;
    assign o_block_number_res = r_out_bn;
    assign o_status           = r_out_st;

    // managed range: min(block_count, MAP_BITS, 65536 - data_base)
    always_comb begin
        logic [bba_pkg::WIDE_W-1:0] bc;
        logic [bba_pkg::WIDE_W-1:0] room;
        logic [bba_pkg::WIDE_W-1:0] lim;
        bc   = bba_pkg::WIDE_W'(r_block_count);
        room = bba_pkg::WIDE_W'(17'h10000) - {1'b0, r_data_base};
        lim  = (bc > bba_pkg::WIDE_W'(bba_pkg::MAP_BITS))
               ? bba_pkg::WIDE_W'(bba_pkg::MAP_BITS) : bc;
        if (lim > room) begin
            lim = room;
        end
        n_n = lim[bba_pkg::CNT_W-1:0];
    end

    assign rdata = r_rd_vld ? r_rd_raw : 64'd0;

    // free path checks
    always_comb begin
        off       = r_bn - r_data_base;
        offw      = off[bba_pkg::GIDX_W-1:6];
        offb      = off[5:0];
        range_bad = (r_bn < r_data_base) ||
                    ({1'b0, off} >= bba_pkg::WIDE_W'(r_n));
    end

    // scan of one word: mask off bits past the range, isolate lowest clear bit
    always_comb begin
        wbase    = {1'b0, r_widx, 6'b0};
        rem_full = (r_n > wbase) ? (r_n - wbase) : '0;
        rem7     = (rem_full >= bba_pkg::CNT_W'(64)) ? 7'd64 : rem_full[6:0];
        for (int b = 0; b < 64; b++) begin
            avail[b] = 7'(b) < rem7;
        end
        free_bits = ~rdata & avail;
        iso       = free_bits & (~free_bits + 64'd1);
        bidx      = '0;
        for (int b = 0; b < 64; b++) begin
            for (int k = 0; k < 6; k++) begin
                if (iso[b] && ((b >> k) & 1) == 1) begin
                    bidx[k] = 1'b1;
                end
            end
        end
        found = |free_bits;
        more  = (wbase + bba_pkg::CNT_W'(64)) < r_n;
    end

    always_comb begin
        flags.in_fire   = in_fire;
        flags.op_free   = (r_op == bba_pkg::OP_FREE);
        flags.scan_end  = found || !more;
        flags.found     = r_found;
        flags.range_bad = range_bad;
        flags.bit_set   = rdata[offb];
        flags.out_free  = out_free;
    end

    // memory port control
    always_comb begin
        case (uop.rd)
            bba_pkg::RD_FIRST: rd_addr = '0;
            bba_pkg::RD_NEXT:  rd_addr = r_widx + 1'b1;
            bba_pkg::RD_OFF:   rd_addr = offw;
            default:           rd_addr = r_widx;
        endcase
        case (uop.wr)
            bba_pkg::WR_SET: begin
                wr_en   = 1'b1;
                wr_addr = r_fw;
                wr_data = r_fword;
            end
            bba_pkg::WR_CLR: begin
                wr_en   = 1'b1;
                wr_addr = offw;
                wr_data = rdata & ~(64'd1 << offb);
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = r_fw;
                wr_data = r_fword;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        r_rd_raw <= r_map[rd_addr];
        r_rd_vld <= r_map_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < bba_pkg::MAP_WORDS; w++) begin
                r_map_vld[w] <= 1'b0;
            end
        end else if (wr_en) begin
            r_map_vld[wr_addr] <= 1'b1;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base   <= '0;
            r_block_count <= bba_pkg::BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bba_pkg::REG_DATA_BASE:   r_data_base   <= i_cfg_data;
                bba_pkg::REG_BLOCK_COUNT: r_block_count <= i_cfg_data[bba_pkg::BC_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (uop.ld_in && in_fire) begin
            r_op <= i_op;
            r_bn <= i_block_number;
            r_n  <= n_n;
        end
        case (uop.rd)
            bba_pkg::RD_FIRST: r_widx <= '0;
            bba_pkg::RD_NEXT:  r_widx <= r_widx + 1'b1;
            default: ;
        endcase
        if (uop.scan) begin
            r_found <= found;
            if (found) begin
                r_fw    <= r_widx;
                r_fword <= rdata | iso;
                r_res   <= r_data_base + bba_pkg::BN_W'({r_widx, bidx});
            end
        end
        case (uop.res)
            bba_pkg::RES_BN:   r_res <= r_bn;
            bba_pkg::RES_ZERO: r_res <= '0;
            default: ;
        endcase
        if (uop.ld_st) begin
            r_st <= uop.st;
        end
        if (push) begin
            r_out_bn <= r_res;
            r_out_st <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // any failure returns block zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != bba_pkg::ST_OK) |-> o_block_number_res == '0)
        else $error("failed request with nonzero block number");

    // scan never tests a word wholly beyond the managed range
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        uop.scan |-> (r_n == '0) || ({1'b0, r_widx, 6'b0} < r_n))
        else $error("scan past managed range");

    // a free only clears a bit that was set
    a_clr_set_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        uop.wr == bba_pkg::WR_CLR |-> rdata[offb] && !range_bad)
        else $error("clearing a bit that is not set");

    // an allocate writes back one more set bit than the word it scanned
    a_set_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        uop.scan && found |=> $countones(r_fword) == $countones($past(rdata)) + 1)
        else $error("allocate does not set exactly one bit");

    // after the result is pushed the block is ready for a new word
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_in_ready)
        else $error("not ready after result push");

endmodule
